>>> sv/sdvf_pkg.sv
`default_nettype none
package sdvf_pkg;

  localparam int VALUE_BITS_DEF   = 32;
  localparam int HEADER_BYTES_DEF = 15;

  localparam int IN_VALUE_W = 32;
  localparam int DIGITS     = 10;
  localparam int BCD_W      = 4 * DIGITS;
  localparam int LEN_W      = 4;
  localparam int CNT_W      = 4;
  localparam int PC_W       = 5;
  localparam int PH_W       = 3;

  localparam logic [PH_W-1:0] PH_IDLE       = 3'd0;
  localparam logic [PH_W-1:0] PH_WAIT_START = 3'd1;
  localparam logic [PH_W-1:0] PH_SKIP_HDR   = 3'd2;
  localparam logic [PH_W-1:0] PH_WAIT_ACK1  = 3'd3;
  localparam logic [PH_W-1:0] PH_WAIT_ACK2  = 3'd4;
  localparam logic [PH_W-1:0] PH_WAIT_FINAL = 3'd5;

  localparam logic [1:0] SRC_CONST  = 2'd0;
  localparam logic [1:0] SRC_SIZE   = 2'd1;
  localparam logic [1:0] SRC_CHAR   = 2'd2;
  localparam logic [1:0] SRC_NEGSUM = 2'd3;

  localparam logic [1:0] J_NONE = 2'd0;
  localparam logic [1:0] J_NACK = 2'd1;
  localparam logic [1:0] J_HDR  = 2'd2;
  localparam logic [1:0] J_MORE = 2'd3;

  localparam logic [1:0] ST_BUSY    = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  localparam logic [7:0] ACK_BYTE  = 8'h06;
  localparam logic [7:0] XON_BYTE  = 8'h13;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  typedef struct packed {
    logic            put;
    logic            txv;
    logic [1:0]      status;
    logic            last;
    logic [1:0]      src;
    logic [7:0]      lit;
    logic            add;
    logic            clr_sum;
    logic            clr_cnt;
    logic            inc_cnt;
    logic            set_ph;
    logic [PH_W-1:0] ph;
    logic [1:0]      jcond;
    logic [PC_W-1:0] jtgt;
    logic            done;
  } ucode_t;

  typedef struct packed {
    logic nack;
    logic hdr_done;
    logic more;
  } cond_t;

endpackage
`default_nettype wire

>>> sv/sdvf_conv.sv
`default_nettype none
module sdvf_conv #(
  parameter int VALUE_BITS = sdvf_pkg::VALUE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          load,
  input  wire logic [sdvf_pkg::IN_VALUE_W-1:0] value,
  output logic                               busy,
  output logic [sdvf_pkg::BCD_W-1:0]         digits,
  output logic                               neg,
  output logic [sdvf_pkg::LEN_W-1:0]         len
);
  import sdvf_pkg::*;

  localparam int W  = (VALUE_BITS > IN_VALUE_W) ? VALUE_BITS : IN_VALUE_W;
  localparam int CW = $clog2(VALUE_BITS);

  localparam logic [1:0] CS_IDLE  = 2'd0;
  localparam logic [1:0] CS_SHIFT = 2'd1;
  localparam logic [1:0] CS_LEN   = 2'd2;

  logic [1:0]            st_r;
  logic [CW-1:0]         cnt_r;
  logic [VALUE_BITS-1:0] mag_r;
  logic [BCD_W-1:0]      bcd_r;
  logic                  neg_r;
  logic [LEN_W-1:0]      len_r;

  logic [W-1:0]          wide;
  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag_in;
  logic [BCD_W-1:0]      adj;
  logic [LEN_W-1:0]      ndig;

  assign wide   = W'(value);
  assign raw    = wide[VALUE_BITS-1:0];
  assign mag_in = raw[VALUE_BITS-1] ? ({VALUE_BITS{1'b0}} - raw) : raw;

  // add-3 correction per bcd digit
  always_comb begin
    adj = bcd_r;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end
    end
  end

  // count of significant digits, at least one
  always_comb begin
    ndig = 4'd1;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) begin
        ndig = LEN_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= CS_IDLE;
      cnt_r <= '0;
    end else begin
      case (st_r)
        CS_IDLE: begin
          if (load) begin
            st_r  <= CS_SHIFT;
            cnt_r <= '0;
          end
        end
        CS_SHIFT: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CW'(VALUE_BITS - 1)) begin
            st_r <= CS_LEN;
          end
        end
        CS_LEN: begin
          st_r <= CS_IDLE;
        end
        default: begin
          st_r <= CS_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == CS_IDLE && load) begin
      neg_r <= raw[VALUE_BITS-1];
      mag_r <= mag_in;
      bcd_r <= '0;
    end else if (st_r == CS_SHIFT) begin
      bcd_r <= {adj[BCD_W-2:0], mag_r[VALUE_BITS-1]};
      mag_r <= mag_r << 1;
    end
    if (st_r == CS_LEN) begin
      len_r <= ndig + {{(LEN_W-1){1'b0}}, neg_r};
    end
  end

  assign busy   = (st_r != CS_IDLE);
  assign digits = bcd_r;
  assign neg    = neg_r;
  assign len    = len_r;

endmodule
`default_nettype wire

>>> sv/sdvf_dpath.sv
`default_nettype none
module sdvf_dpath #(
  parameter int HEADER_BYTES = sdvf_pkg::HEADER_BYTES_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      load,
  input  wire logic                      take,
  input  wire logic [7:0]                rx_byte,
  input  wire sdvf_pkg::ucode_t          ctrl,
  input  wire logic                      fire,
  input  wire logic [sdvf_pkg::BCD_W-1:0] digits,
  input  wire logic                      neg,
  input  wire logic [sdvf_pkg::LEN_W-1:0] len,
  output sdvf_pkg::cond_t                cond,
  output logic                           out_free,
  output logic                           out_tvalid,
  input  wire logic                      out_tready,
  output logic [7:0]                     out_tdata,
  output logic [2:0]                     out_tuser,
  output logic                           out_tlast
);
  import sdvf_pkg::*;

  logic [CNT_W-1:0] cnt_r;
  logic [7:0]       sum_r;
  logic [7:0]       rx_r;
  logic             out_valid_r;
  logic [7:0]       out_byte_r;
  logic             out_txv_r;
  logic [1:0]       out_st_r;
  logic             out_last_r;

  logic [LEN_W-1:0] didx;
  logic [BCD_W-1:0] dsh;
  logic [7:0]       chr;
  logic [7:0]       byte_sel;

  assign didx = len - LEN_W'(1) - LEN_W'(cnt_r);
  assign dsh  = digits >> {didx, 2'b00};
  assign chr  = (neg && cnt_r == '0) ? CH_MINUS : (CH_ZERO + {4'b0000, dsh[3:0]});

  always_comb begin
    case (ctrl.src)
      SRC_CONST:  byte_sel = ctrl.lit;
      SRC_SIZE:   byte_sel = 8'(len);
      SRC_CHAR:   byte_sel = chr;
      SRC_NEGSUM: byte_sel = 8'd0 - sum_r;
      default:    byte_sel = ctrl.lit;
    endcase
  end

  assign cond.nack     = (rx_r != ACK_BYTE);
  assign cond.hdr_done = (cnt_r == CNT_W'(HEADER_BYTES - 1));
  assign cond.more     = ({1'b0, cnt_r} + 5'd1) < {1'b0, len};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= '0;
    end else if (fire && ctrl.clr_cnt) begin
      cnt_r <= '0;
    end else if (fire && ctrl.inc_cnt) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rx_r <= rx_byte;
    end
    if (fire && ctrl.clr_sum) begin
      sum_r <= '0;
    end else if (fire && ctrl.add) begin
      sum_r <= sum_r + byte_sel;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && ctrl.put) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ctrl.put) begin
      out_byte_r <= ctrl.txv ? byte_sel : 8'd0;
      out_txv_r  <= ctrl.txv;
      out_st_r   <= ctrl.status;
      out_last_r <= ctrl.last;
    end
  end

  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = {out_st_r, out_txv_r};
  assign out_tlast  = out_last_r;

endmodule
`default_nettype wire

>>> sv/sdvf_useq.sv
`default_nettype none
module sdvf_useq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire logic             take,
  input  wire sdvf_pkg::cond_t  cond,
  input  wire logic             out_free,
  output sdvf_pkg::ucode_t      ctrl,
  output logic                  fire,
  output logic                  busy
);
  import sdvf_pkg::*;

  localparam logic [PC_W-1:0] A_IDLE     = 5'd0;
  localparam logic [PC_W-1:0] A_START    = 5'd1;
  localparam logic [PC_W-1:0] A_SKIP     = 5'd2;
  localparam logic [PC_W-1:0] A_SKIP_INC = 5'd3;
  localparam logic [PC_W-1:0] A_HDR      = 5'd4;
  localparam logic [PC_W-1:0] A_HDR_SIZE = 5'd15;
  localparam logic [PC_W-1:0] A_HDR_SUM  = 5'd18;
  localparam logic [PC_W-1:0] A_ACK1     = 5'd19;
  localparam logic [PC_W-1:0] A_TEXT     = 5'd20;
  localparam logic [PC_W-1:0] A_CHAR     = 5'd21;
  localparam logic [PC_W-1:0] A_TSUM     = 5'd22;
  localparam logic [PC_W-1:0] A_ACK2     = 5'd23;
  localparam logic [PC_W-1:0] A_ACK2_OK  = 5'd24;
  localparam logic [PC_W-1:0] A_REFUSE   = 5'd25;
  localparam logic [PC_W-1:0] A_FINAL    = 5'd26;

  // fixed header bytes, size low byte comes from the datapath
  function automatic logic [7:0] hdr_lit(input logic [PC_W-1:0] idx);
    case (idx)
      5'd0:    hdr_lit = CH_COLON;
      5'd1:    hdr_lit = 8'h4e;
      5'd2:    hdr_lit = 8'h41;
      5'd3:    hdr_lit = 8'h56;
      5'd5:    hdr_lit = 8'h01;
      5'd9:    hdr_lit = 8'h01;
      5'd12:   hdr_lit = 8'hff;
      5'd13:   hdr_lit = 8'h41;
      default: hdr_lit = 8'h00;
    endcase
  endfunction

  function automatic ucode_t rom(input logic [PC_W-1:0] a);
    ucode_t u;
    u = '0;
    if (a inside {[A_HDR:A_HDR_SUM-5'd1]}) begin
      u.put     = 1'b1;
      u.txv     = 1'b1;
      u.src     = (a == A_HDR_SIZE) ? SRC_SIZE : SRC_CONST;
      u.lit     = hdr_lit(a - A_HDR);
      u.add     = (a != A_HDR);
      u.clr_sum = (a == A_HDR);
    end else begin
      case (a)
        A_START: begin
          u.put = 1'b1; u.txv = 1'b1; u.lit = XON_BYTE; u.last = 1'b1;
          u.clr_cnt = 1'b1; u.set_ph = 1'b1; u.ph = PH_SKIP_HDR; u.done = 1'b1;
        end
        A_SKIP: begin
          u.jcond = J_HDR; u.jtgt = A_HDR;
        end
        A_SKIP_INC: begin
          u.inc_cnt = 1'b1; u.done = 1'b1;
        end
        A_HDR_SUM: begin
          u.put = 1'b1; u.txv = 1'b1; u.src = SRC_NEGSUM; u.last = 1'b1;
          u.clr_cnt = 1'b1; u.set_ph = 1'b1; u.ph = PH_WAIT_ACK1; u.done = 1'b1;
        end
        A_ACK1: begin
          u.jcond = J_NACK; u.jtgt = A_REFUSE;
        end
        A_TEXT: begin
          u.put = 1'b1; u.txv = 1'b1; u.lit = CH_COLON;
          u.clr_sum = 1'b1; u.clr_cnt = 1'b1;
        end
        A_CHAR: begin
          u.put = 1'b1; u.txv = 1'b1; u.src = SRC_CHAR; u.add = 1'b1;
          u.inc_cnt = 1'b1; u.jcond = J_MORE; u.jtgt = A_CHAR;
        end
        A_TSUM: begin
          u.put = 1'b1; u.txv = 1'b1; u.src = SRC_NEGSUM; u.last = 1'b1;
          u.set_ph = 1'b1; u.ph = PH_WAIT_ACK2; u.done = 1'b1;
        end
        A_ACK2: begin
          u.jcond = J_NACK; u.jtgt = A_REFUSE;
        end
        A_ACK2_OK: begin
          u.set_ph = 1'b1; u.ph = PH_WAIT_FINAL; u.done = 1'b1;
        end
        A_REFUSE: begin
          u.put = 1'b1; u.status = ST_REFUSED; u.last = 1'b1;
          u.set_ph = 1'b1; u.ph = PH_IDLE; u.done = 1'b1;
        end
        A_FINAL: begin
          u.put = 1'b1; u.status = ST_DONE; u.last = 1'b1;
          u.set_ph = 1'b1; u.ph = PH_IDLE; u.done = 1'b1;
        end
        default: begin
          u.set_ph = 1'b1; u.ph = PH_IDLE; u.done = 1'b1;
        end
      endcase
    end
    return u;
  endfunction

  function automatic logic [PC_W-1:0] entry(input logic [PH_W-1:0] ph);
    case (ph)
      PH_WAIT_START: entry = A_START;
      PH_SKIP_HDR:   entry = A_SKIP;
      PH_WAIT_ACK1:  entry = A_ACK1;
      PH_WAIT_ACK2:  entry = A_ACK2;
      PH_WAIT_FINAL: entry = A_FINAL;
      default:       entry = A_IDLE;
    endcase
  endfunction

  logic            run_r;
  logic [PC_W-1:0] pc_r;
  logic [PH_W-1:0] ph_r;
  logic            jmp;

  assign ctrl = rom(pc_r);
  assign fire = run_r && out_free;
  assign busy = run_r;

  always_comb begin
    case (ctrl.jcond)
      J_NONE:  jmp = 1'b0;
      J_NACK:  jmp = cond.nack;
      J_HDR:   jmp = cond.hdr_done;
      J_MORE:  jmp = cond.more;
      default: jmp = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      pc_r  <= A_IDLE;
      ph_r  <= PH_IDLE;
    end else begin
      if (load) begin
        ph_r <= PH_WAIT_START;
      end
      if (take) begin
        run_r <= 1'b1;
        pc_r  <= entry(ph_r);
      end
      if (fire) begin
        if (ctrl.set_ph) begin
          ph_r <= ctrl.ph;
        end
        if (jmp) begin
          pc_r <= ctrl.jtgt;
        end else if (ctrl.done) begin
          run_r <= 1'b0;
        end else begin
          pc_r <= pc_r + 1'b1;
        end
      end
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r && !out_free) |=> (run_r && $stable(pc_r)))
    else $error("sequencer moved while result register was blocked");

  a_done_stops: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && ctrl.done && !jmp) |=> !run_r)
    else $error("sequencer kept running after a final step");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> (pc_r <= A_FINAL))
    else $error("step counter outside the control program");

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> (!take && !load))
    else $error("request taken while the sequencer was running");

endmodule
`default_nettype wire

>>> sv/send_decimal_value_frame.sv
// start request (tuser 0): digit conversion runs in the one-bit-per-cycle binary to bcd
//   shifter, then a length step; no result, next request taken once conversion is done
// partner byte (tuser 1): results go out through the output register one per cycle
//   while out_tready is high, up to 15 (header); next request taken once the last is registered
// out_tready low stalls the control program; a result waits in the output register
// reset (rst_n low, synchronous): idle phase, output register empty, nothing pending
`default_nettype none
module send_decimal_value_frame #(
  parameter int VALUE_BITS   = sdvf_pkg::VALUE_BITS_DEF,
  parameter int HEADER_BYTES = sdvf_pkg::HEADER_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // value[31:0], rx_byte[39:32]
  input  wire logic        in_tuser,   // mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // tx_byte[7:0]
  output logic [2:0]       out_tuser,  // tx_valid[0], status[2:1]
  output logic             out_tlast   // last
);
  import sdvf_pkg::*;

  logic             acc;
  logic             load;
  logic             take;
  logic             conv_busy;
  logic             seq_busy;
  logic             fire;
  logic             out_free;
  logic [BCD_W-1:0] digits;
  logic             neg;
  logic [LEN_W-1:0] len;
  ucode_t           ctrl;
  cond_t            cond;

  assign in_tready = !seq_busy && !conv_busy;
  assign acc       = in_tvalid && in_tready;
  assign load      = acc && !in_tuser;
  assign take      = acc && in_tuser;

  sdvf_conv #(
    .VALUE_BITS(VALUE_BITS)
  ) u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (load),
    .value  (in_tdata[31:0]),
    .busy   (conv_busy),
    .digits (digits),
    .neg    (neg),
    .len    (len)
  );

  sdvf_useq u_useq (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .take     (take),
    .cond     (cond),
    .out_free (out_free),
    .ctrl     (ctrl),
    .fire     (fire),
    .busy     (seq_busy)
  );

  sdvf_dpath #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .take       (take),
    .rx_byte    (in_tdata[39:32]),
    .ctrl       (ctrl),
    .fire       (fire),
    .digits     (digits),
    .neg        (neg),
    .len        (len),
    .cond       (cond),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

>>> test/send_decimal_value_frame_test.sv
`default_nettype none
module send_decimal_value_frame_test;
  import sdvf_pkg::*;

  localparam logic MODE_START = 1'b0;
  localparam logic MODE_BYTE  = 1'b1;
  localparam int   ITEM_GOAL  = 410;
  localparam int   CALM_FROM  = 350;
  localparam int   STALL_LIMIT = 3000;

  localparam logic [7:0] HDR_PREFIX [10] = '{
    8'h3a, 8'h4e, 8'h41, 8'h56, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h01
  };

  typedef enum logic [2:0] {
    CHK_PREDICT, CHK_SILENT, CHK_XON, CHK_DONE, CHK_REFUSED
  } check_kind_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] value;
    logic [7:0]  rx;
    logic [4:0]  reps;
    check_kind_t kind;
  } stim_row_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
    logic [1:0] status;
    logic       last;
  } tx_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [7:0]  out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  send_decimal_value_frame dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #6 clk = ~clk;

  stim_row_t directed_rows [11] = '{
    '{MODE_BYTE,  32'h0000_0000, ACK_BYTE, 5'd1,  CHK_SILENT},
    '{MODE_START, 32'h7fff_ffff, 8'h00,    5'd1,  CHK_SILENT},
    '{MODE_BYTE,  32'h0000_0000, XON_BYTE, 5'd1,  CHK_XON},
    '{MODE_BYTE,  32'hffff_ffff, 8'h5a,    5'd3,  CHK_SILENT},
    '{MODE_START, 32'h8000_0000, 8'hff,    5'd1,  CHK_SILENT},
    '{MODE_BYTE,  32'h0000_0000, 8'hff,    5'd1,  CHK_XON},
    '{MODE_BYTE,  32'h0000_0000, 8'h00,    5'd14, CHK_SILENT},
    '{MODE_BYTE,  32'h0000_0000, ACK_BYTE, 5'd1,  CHK_PREDICT},
    '{MODE_BYTE,  32'h0000_0000, ACK_BYTE, 5'd1,  CHK_PREDICT},
    '{MODE_BYTE,  32'h0000_0000, ACK_BYTE, 5'd1,  CHK_SILENT},
    '{MODE_BYTE,  32'h0000_0000, 8'h00,    5'd1,  CHK_DONE}
  };

  // link state as the partner sees it
  logic [PH_W-1:0] link_phase;
  logic [3:0]      skip_count;
  logic [3:0]      text_len;
  logic [7:0]      text_chars [16];

  tx_result_t expected_tx [$];
  tx_result_t step_results [$];
  int         mismatches;
  int         requests_sent;
  int         gap_pct;
  bit         idle_on;
  int         stall_left;
  int         quiet_cycles;

  task automatic push_tx(input logic [7:0] tx_byte, input logic valid, input logic [1:0] status);
    tx_result_t r;
    r.tx_byte  = tx_byte;
    r.tx_valid = valid;
    r.status   = status;
    r.last     = 1'b0;
    step_results.push_back(r);
  endtask

  task automatic load_decimal_text(input logic [31:0] value);
    logic [31:0] mag;
    logic [3:0]  digits [10];
    int          n;
    int          neg;
    neg = value[31];
    mag = value[31] ? (~value + 32'd1) : value;
    n = 0;
    do begin
      digits[n] = 4'(mag % 10);
      mag = mag / 10;
      n++;
    end while (mag != 0);
    if (neg != 0) text_chars[0] = CH_MINUS;
    for (int i = 0; i < n; i++) text_chars[neg + i] = CH_ZERO + 8'(digits[n - 1 - i]);
    text_len = 4'(n + neg);
  endtask

  task automatic predict_link_step(input logic mode, input logic [31:0] value,
                                   input logic [7:0] rx, output bit ignored);
    logic [7:0]  hdr [15];
    logic [7:0]  sum;
    logic [15:0] size16;
    step_results.delete();
    ignored = 1'b0;
    if (mode == MODE_START) begin
      load_decimal_text(value);
      link_phase = PH_WAIT_START;
      skip_count = 4'd0;
    end else begin
      case (link_phase)
        PH_IDLE: begin
          ignored = 1'b1;
        end
        PH_WAIT_START: begin
          push_tx(XON_BYTE, 1'b1, ST_BUSY);
          skip_count = 4'd0;
          link_phase = PH_SKIP_HDR;
        end
        PH_SKIP_HDR: begin
          skip_count = skip_count + 4'd1;
          if (skip_count >= HEADER_BYTES_DEF) begin
            size16 = {12'd0, text_len};
            for (int i = 0; i < 10; i++) hdr[i] = HDR_PREFIX[i];
            hdr[10] = size16[15:8];
            hdr[11] = size16[7:0];
            hdr[12] = 8'hff;
            hdr[13] = 8'h41;
            sum = 8'd0;
            for (int i = 1; i < 14; i++) sum = sum + hdr[i];
            hdr[14] = ~sum + 8'd1;
            for (int i = 0; i < 15; i++) push_tx(hdr[i], 1'b1, ST_BUSY);
            skip_count = 4'd0;
            link_phase = PH_WAIT_ACK1;
          end
        end
        PH_WAIT_ACK1: begin
          if (rx == ACK_BYTE) begin
            push_tx(CH_COLON, 1'b1, ST_BUSY);
            sum = 8'd0;
            for (int i = 0; i < text_len; i++) begin
              push_tx(text_chars[i], 1'b1, ST_BUSY);
              sum = sum + text_chars[i];
            end
            push_tx(~sum + 8'd1, 1'b1, ST_BUSY);
            link_phase = PH_WAIT_ACK2;
          end else begin
            push_tx(8'h00, 1'b0, ST_REFUSED);
            link_phase = PH_IDLE;
          end
        end
        PH_WAIT_ACK2: begin
          if (rx == ACK_BYTE) begin
            link_phase = PH_WAIT_FINAL;
          end else begin
            push_tx(8'h00, 1'b0, ST_REFUSED);
            link_phase = PH_IDLE;
          end
        end
        PH_WAIT_FINAL: begin
          push_tx(8'h00, 1'b0, ST_DONE);
          link_phase = PH_IDLE;
        end
        default: begin
          link_phase = PH_IDLE;
        end
      endcase
    end
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
  endtask

  task automatic send_request(input logic mode, input logic [31:0] value,
                              input logic [7:0] rx, input check_kind_t kind);
    bit ignored;
    if (idle_on && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {rx, value};
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    predict_link_step(mode, value, rx, ignored);
    case (kind)
      CHK_PREDICT: foreach (step_results[i]) expected_tx.push_back(step_results[i]);
      CHK_XON:     expected_tx.push_back('{XON_BYTE, 1'b1, ST_BUSY, 1'b1});
      CHK_DONE:    expected_tx.push_back('{8'h00, 1'b0, ST_DONE, 1'b1});
      CHK_REFUSED: expected_tx.push_back('{8'h00, 1'b0, ST_REFUSED, 1'b1});
      default: ;
    endcase
    if (!ignored) requests_sent++;
  endtask

  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom();
      1: v = $urandom_range(0, 999);
      2: v = 32'd0;
      3: v = 32'h8000_0000;
      4: v = 32'h7fff_ffff;
      default: v = $urandom_range(0, 99999);
    endcase
    if ($urandom_range(0, 1) == 1 && v != 32'h8000_0000) v = ~v + 32'd1;
    return v;
  endfunction

  function automatic logic [7:0] pick_reply(input int ack_pct);
    logic [7:0] b;
    if ($urandom_range(0, 99) < ack_pct) return ACK_BYTE;
    b = 8'($urandom_range(0, 254));
    if (b >= ACK_BYTE) b = b + 8'd1;
    return b;
  endfunction

  task automatic run_transfer();
    send_request(MODE_START, pick_value(), 8'($urandom()), CHK_PREDICT);
    send_request(MODE_BYTE, $urandom(), 8'($urandom()), CHK_PREDICT);
    for (int i = 0; i < HEADER_BYTES_DEF; i++) begin
      if ($urandom_range(0, 99) < 2) begin
        send_request(MODE_START, pick_value(), 8'($urandom()), CHK_PREDICT);
        return;
      end
      send_request(MODE_BYTE, $urandom(), 8'($urandom()), CHK_PREDICT);
    end
    send_request(MODE_BYTE, $urandom(), pick_reply(85), CHK_PREDICT);
    if (link_phase != PH_WAIT_ACK2) return;
    send_request(MODE_BYTE, $urandom(), pick_reply(85), CHK_PREDICT);
    if (link_phase != PH_WAIT_FINAL) return;
    send_request(MODE_BYTE, $urandom(), 8'($urandom()), CHK_PREDICT);
  endtask

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    tx_result_t want;
    if (rst_n === 1'b1 && out_tvalid && out_tready) begin
      if (expected_tx.size() == 0) begin
        $display("%0t: result with nothing expected, expected none actual %h/%h/%b",
                 $time, out_tdata, out_tuser, out_tlast);
        mismatches++;
      end else begin
        want = expected_tx.pop_front();
        check_field("tx_byte", want.tx_byte, out_tdata);
        check_field("tx_valid", want.tx_valid, out_tuser[0]);
        check_field("status", want.status, out_tuser[2:1]);
        check_field("last", want.last, out_tlast);
      end
    end
  end

  // random back-pressure on the result side
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || !idle_on) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else if ($urandom_range(0, 99) < 8) begin
      stall_left <= $urandom_range(1, 15);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    mismatches    = 0;
    requests_sent = 0;
    quiet_cycles  = 0;
    stall_left    = 0;
    gap_pct       = 25;
    idle_on       = 1'b1;
    link_phase    = PH_IDLE;
    skip_count    = 4'd0;
    text_len      = 4'd0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= MODE_START;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      for (int k = 0; k < directed_rows[r].reps; k++) begin
        send_request(directed_rows[r].mode, directed_rows[r].value,
                     directed_rows[r].rx, directed_rows[r].kind);
      end
    end

    while (requests_sent < ITEM_GOAL) begin
      if (requests_sent >= CALM_FROM) idle_on = 1'b0;
      case ($urandom_range(0, 3))
        0: gap_pct = 0;
        1: gap_pct = 10;
        2: gap_pct = 25;
        default: gap_pct = 50;
      endcase
      if ($urandom_range(0, 99) < 80) begin
        run_transfer();
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_request(($urandom_range(0, 4) == 0) ? MODE_START : MODE_BYTE,
                       $urandom(), 8'($urandom()), CHK_PREDICT);
        end
      end
    end
    in_tvalid <= 1'b0;

    while (expected_tx.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> send_decimal_value_frame.f
sv/sdvf_pkg.sv
sv/sdvf_conv.sv
sv/sdvf_dpath.sv
sv/sdvf_useq.sv
sv/send_decimal_value_frame.sv
test/send_decimal_value_frame_test.sv
